// ===== design/order_book_matcher_macros.svh =====
// Assertion macros used by the order book matcher checker.
`ifndef ORDER_BOOK_MATCHER_MACROS_SVH
`define ORDER_BOOK_MATCHER_MACROS_SVH
// same-cycle implication
`define OBM_ASSERT_NOW(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (c)) \
        else $error("order book check failed");
// next-cycle implication
`define OBM_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (c)) \
        else $error("order book check failed");
`endif

// ===== design/obm_pkg.sv =====
// Types and codes shared by the order book matcher modules.
package obm_pkg;

    localparam int unsigned SLOT_IW = 6;
    localparam int unsigned SUM_W   = 38;

    localparam logic [2:0] REQ_ADD    = 3'd0;
    localparam logic [2:0] REQ_CANCEL = 3'd1;
    localparam logic [2:0] REQ_AMD_Q  = 3'd2;
    localparam logic [2:0] REQ_AMD_P  = 3'd3;
    localparam logic [2:0] REQ_AMD_QP = 3'd4;

    localparam logic [1:0] TIF_GTC = 2'd0;
    localparam logic [1:0] TIF_IOC = 2'd1;
    localparam logic [1:0] TIF_FOK = 2'd2;

    localparam logic [1:0] FK_AGGR = 2'd0;
    localparam logic [1:0] FK_REST = 2'd1;
    localparam logic [1:0] FK_BOTH = 2'd2;

    localparam logic [3:0] STS_TRADE     = 4'd0;
    localparam logic [3:0] STS_RESTED    = 4'd1;
    localparam logic [3:0] STS_DONE      = 4'd2;
    localparam logic [3:0] STS_KILLED    = 4'd3;
    localparam logic [3:0] STS_CANCELLED = 4'd4;
    localparam logic [3:0] STS_CANNOT    = 4'd5;
    localparam logic [3:0] STS_REMOVED   = 4'd6;
    localparam logic [3:0] STS_IN_PLACE  = 4'd7;
    localparam logic [3:0] STS_AMENDED   = 4'd8;
    localparam logic [3:0] STS_FULL      = 4'd9;

    typedef enum logic [2:0] {
        CO_NONE,
        CO_FILL,
        CO_CLEAR,
        CO_WRITE,
        CO_TOTAL,
        CO_TOTAL_ARR
    } t_cell_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_ADD_EVAL,
        S_TGT_EVAL
    } t_state;

    // slot update broadcast to the cells; filled carries the amount on a fill
    typedef struct packed {
        t_cell_op           op;
        logic [SLOT_IW-1:0] idx;
        logic [31:0]        id;
        logic [15:0]        price;
        logic               side;
        logic [31:0]        total;
        logic [31:0]        filled;
        logic [31:0]        arrival;
    } t_cell_cmd;

    // search context broadcast to the cells
    typedef struct packed {
        logic        side;
        logic        market;
        logic [15:0] price;
        logic [31:0] id;
    } t_ctx;

    // running result handed from cell to cell
    typedef struct packed {
        logic               m_found;
        logic [SLOT_IW-1:0] m_idx;
        logic [31:0]        m_id;
        logic [15:0]        m_price;
        logic [31:0]        m_arr;
        logic [31:0]        m_avail;
        logic               f_found;
        logic [SLOT_IW-1:0] f_idx;
        logic [31:0]        f_arr;
        logic               f_side;
        logic [15:0]        f_price;
        logic [31:0]        f_total;
        logic [31:0]        f_filled;
        logic               e_found;
        logic [SLOT_IW-1:0] e_idx;
        logic [SUM_W-1:0]   sum;
    } t_scan;

endpackage

// ===== design/order_book_matcher.sv =====
// Order book matcher top level: slot cell chain and request sequencer.
// A request is taken when start is high while busy is low. Every book search
// walks the chain of ORDER_SLOTS cells and is followed by an evaluation state
// that acts on the result. An add runs a fresh search after each fill;
// cancel and amend take one search, and an amend that re-adds the
// order continues as an add. Unknown request types answer from idle with no search.
// Each result is shown for one cycle with o_valid and cannot be held off; the
// closing status carries o_last and busy is already low in that cycle.
module order_book_matcher #(
    parameter int unsigned ORDER_SLOTS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_req_type,
    input  logic [31:0] i_order_id,
    input  logic        i_side,
    input  logic        i_is_market,
    input  logic [15:0] i_limit_price,
    input  logic [31:0] i_quantity,
    input  logic [1:0]  i_time_in_force,
    output logic        o_valid,
    output logic [31:0] o_aggressor_id,
    output logic [31:0] o_resting_id,
    output logic [15:0] o_trade_price,
    output logic [31:0] o_trade_quantity,
    output logic        o_aggressor_side,
    output logic [1:0]  o_fill_kind,
    output logic [3:0]  o_status,
    output logic [31:0] o_rested_filled,
    output logic        o_last
);

    obm_pkg::t_scan     w_chain [ORDER_SLOTS+1];
    obm_pkg::t_cell_cmd w_cmd;
    obm_pkg::t_ctx      w_ctx;

    assign w_chain[0] = '0;

    for (genvar g = 0; g < ORDER_SLOTS; g++) begin : g_cell
        obm_cell #(
            .CELL_IDX(g)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_cmd  (w_cmd),
            .i_ctx  (w_ctx),
            .i_scan (w_chain[g]),
            .o_scan (w_chain[g+1])
        );
    end

    obm_ctrl #(
        .ORDER_SLOTS(ORDER_SLOTS)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_req_type      (i_req_type),
        .i_order_id      (i_order_id),
        .i_side          (i_side),
        .i_is_market     (i_is_market),
        .i_limit_price   (i_limit_price),
        .i_quantity      (i_quantity),
        .i_time_in_force (i_time_in_force),
        .i_scan          (w_chain[ORDER_SLOTS]),
        .o_cmd           (w_cmd),
        .o_ctx           (w_ctx),
        .o_valid         (o_valid),
        .o_aggressor_id  (o_aggressor_id),
        .o_resting_id    (o_resting_id),
        .o_trade_price   (o_trade_price),
        .o_trade_quantity(o_trade_quantity),
        .o_aggressor_side(o_aggressor_side),
        .o_fill_kind     (o_fill_kind),
        .o_status        (o_status),
        .o_rested_filled (o_rested_filled),
        .o_last          (o_last)
    );

endmodule

// ===== design/obm_cell.sv =====
// One book slot: holds a resting order and folds it into the passing scan record.
module obm_cell #(
    parameter int unsigned CELL_IDX = 0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  obm_pkg::t_cell_cmd i_cmd,
    input  obm_pkg::t_ctx     i_ctx,
    input  obm_pkg::t_scan    i_scan,
    output obm_pkg::t_scan    o_scan
);

    logic        r_valid;
    logic [31:0] r_id;
    logic [15:0] r_price;
    logic        r_side;
    logic [31:0] r_total;
    logic [31:0] r_filled;
    logic [31:0] r_arrival;
    obm_pkg::t_scan r_scan;
    obm_pkg::t_scan n_scan;

    logic        w_hit;
    logic [31:0] w_avail;
    logic        w_can;
    logic        w_before;
    logic        w_take_m;
    logic        w_take_f;

    assign w_hit   = (i_cmd.idx == obm_pkg::SLOT_IW'(CELL_IDX));
    assign w_avail = r_total - r_filled;

    always_comb begin
        w_can = r_valid && (r_side != i_ctx.side) &&
                (i_ctx.market || (i_ctx.side == 1'b0 ? r_price <= i_ctx.price
                                                     : r_price >= i_ctx.price));
        if (r_price != i_scan.m_price) begin
            w_before = (i_ctx.side == 1'b0) ? (r_price < i_scan.m_price)
                                            : (r_price > i_scan.m_price);
        end else begin
            w_before = r_arrival < i_scan.m_arr;
        end
        w_take_m = w_can && (!i_scan.m_found || w_before);
        w_take_f = r_valid && (r_id == i_ctx.id) &&
                   (!i_scan.f_found || r_arrival > i_scan.f_arr);
        n_scan = i_scan;
        if (w_take_m) begin
            n_scan.m_found = 1'b1;
            n_scan.m_idx   = obm_pkg::SLOT_IW'(CELL_IDX);
            n_scan.m_id    = r_id;
            n_scan.m_price = r_price;
            n_scan.m_arr   = r_arrival;
            n_scan.m_avail = w_avail;
        end
        if (w_take_f) begin
            n_scan.f_found  = 1'b1;
            n_scan.f_idx    = obm_pkg::SLOT_IW'(CELL_IDX);
            n_scan.f_arr    = r_arrival;
            n_scan.f_side   = r_side;
            n_scan.f_price  = r_price;
            n_scan.f_total  = r_total;
            n_scan.f_filled = r_filled;
        end
        if (!r_valid && !i_scan.e_found) begin
            n_scan.e_found = 1'b1;
            n_scan.e_idx   = obm_pkg::SLOT_IW'(CELL_IDX);
        end
        if (w_can) begin
            n_scan.sum = i_scan.sum + {{(obm_pkg::SUM_W-32){1'b0}}, w_avail};
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan <= n_scan;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_hit) begin
            case (i_cmd.op)
                obm_pkg::CO_CLEAR: r_valid <= 1'b0;
                obm_pkg::CO_WRITE: r_valid <= 1'b1;
                default:           r_valid <= r_valid;
            endcase
        end
        if (w_hit) begin
            case (i_cmd.op)
                obm_pkg::CO_FILL: begin
                    r_filled <= r_filled + i_cmd.filled;
                end
                obm_pkg::CO_WRITE: begin
                    r_id      <= i_cmd.id;
                    r_price   <= i_cmd.price;
                    r_side    <= i_cmd.side;
                    r_total   <= i_cmd.total;
                    r_filled  <= i_cmd.filled;
                    r_arrival <= i_cmd.arrival;
                end
                obm_pkg::CO_TOTAL: begin
                    r_total <= i_cmd.total;
                end
                obm_pkg::CO_TOTAL_ARR: begin
                    r_total   <= i_cmd.total;
                    r_arrival <= i_cmd.arrival;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_scan = r_scan;

endmodule

// ===== design/obm_ctrl.sv =====
// Request sequencer: runs scans over the cell chain, emits trades and statuses.
module obm_ctrl #(
    parameter int unsigned ORDER_SLOTS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         i_req_type,
    input  logic [31:0]        i_order_id,
    input  logic               i_side,
    input  logic               i_is_market,
    input  logic [15:0]        i_limit_price,
    input  logic [31:0]        i_quantity,
    input  logic [1:0]         i_time_in_force,
    input  obm_pkg::t_scan     i_scan,
    output obm_pkg::t_cell_cmd o_cmd,
    output obm_pkg::t_ctx      o_ctx,
    output logic               o_valid,
    output logic [31:0]        o_aggressor_id,
    output logic [31:0]        o_resting_id,
    output logic [15:0]        o_trade_price,
    output logic [31:0]        o_trade_quantity,
    output logic               o_aggressor_side,
    output logic [1:0]         o_fill_kind,
    output logic [3:0]         o_status,
    output logic [31:0]        o_rested_filled,
    output logic               o_last
);

    localparam int unsigned CNT_W     = obm_pkg::SLOT_IW + 1;
    localparam int unsigned SCAN_LAST = ORDER_SLOTS + 1;

    obm_pkg::t_state    r_state, n_state;
    obm_pkg::t_state    r_after, n_after;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [2:0]         r_req, n_req;
    logic [31:0]        r_qty, n_qty;
    obm_pkg::t_ctx      r_ctx, n_ctx;
    logic [31:0]        r_rem, n_rem;
    logic [31:0]        r_oqty, n_oqty;
    logic [1:0]         r_tif, n_tif;
    logic               r_amend, n_amend;
    logic               r_first, n_first;
    logic [31:0]        r_arrival, n_arrival;
    obm_pkg::t_cell_cmd r_cmd, n_cmd;
    logic               r_valid, n_valid;
    logic [31:0]        r_rest_id, n_rest_id;
    logic [15:0]        r_px, n_px;
    logic [31:0]        r_tq, n_tq;
    logic               r_oside, n_oside;
    logic [1:0]         r_kind, n_kind;
    logic [3:0]         r_sts, n_sts;
    logic [31:0]        r_rf, n_rf;
    logic               r_last, n_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= obm_pkg::S_IDLE;
            r_after   <= obm_pkg::S_IDLE;
            r_cnt     <= '0;
            r_arrival <= '0;
            r_cmd.op  <= obm_pkg::CO_NONE;
            r_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_after   <= n_after;
            r_cnt     <= n_cnt;
            r_arrival <= n_arrival;
            r_cmd.op  <= n_cmd.op;
            r_valid   <= n_valid;
        end
        r_cmd.idx     <= n_cmd.idx;
        r_cmd.id      <= n_cmd.id;
        r_cmd.price   <= n_cmd.price;
        r_cmd.side    <= n_cmd.side;
        r_cmd.total   <= n_cmd.total;
        r_cmd.filled  <= n_cmd.filled;
        r_cmd.arrival <= n_cmd.arrival;
        r_req     <= n_req;
        r_qty     <= n_qty;
        r_ctx     <= n_ctx;
        r_rem     <= n_rem;
        r_oqty    <= n_oqty;
        r_tif     <= n_tif;
        r_amend   <= n_amend;
        r_first   <= n_first;
        r_rest_id <= n_rest_id;
        r_px      <= n_px;
        r_tq      <= n_tq;
        r_oside   <= n_oside;
        r_kind    <= n_kind;
        r_sts     <= n_sts;
        r_rf      <= n_rf;
        r_last    <= n_last;
    end

    always_comb begin
        n_state   = r_state;
        n_after   = r_after;
        n_cnt     = r_cnt;
        n_req     = r_req;
        n_qty     = r_qty;
        n_ctx     = r_ctx;
        n_rem     = r_rem;
        n_oqty    = r_oqty;
        n_tif     = r_tif;
        n_amend   = r_amend;
        n_first   = r_first;
        n_arrival = r_arrival;
        n_cmd     = r_cmd;
        n_cmd.op  = obm_pkg::CO_NONE;
        n_valid   = 1'b0;
        n_rest_id = '0;
        n_px      = '0;
        n_tq      = '0;
        n_oside   = 1'b0;
        n_kind    = obm_pkg::FK_AGGR;
        n_sts     = obm_pkg::STS_CANNOT;
        n_rf      = '0;
        n_last    = 1'b1;

        unique case (r_state)
            obm_pkg::S_IDLE: begin
                if (start) begin
                    n_req        = i_req_type;
                    n_qty        = i_quantity;
                    n_ctx.side   = i_side;
                    n_ctx.market = i_is_market;
                    n_ctx.price  = i_limit_price;
                    n_ctx.id     = i_order_id;
                    n_rem        = i_quantity;
                    n_oqty       = i_quantity;
                    n_tif        = i_time_in_force;
                    n_amend      = 1'b0;
                    n_first      = 1'b1;
                    n_cnt        = '0;
                    if (i_req_type == obm_pkg::REQ_ADD) begin
                        n_state = obm_pkg::S_SCAN;
                        n_after = obm_pkg::S_ADD_EVAL;
                    end else if (i_req_type <= obm_pkg::REQ_AMD_QP) begin
                        n_state = obm_pkg::S_SCAN;
                        n_after = obm_pkg::S_TGT_EVAL;
                    end else begin
                        n_valid = 1'b1;
                        n_sts   = obm_pkg::STS_CANNOT;
                    end
                end
            end
            obm_pkg::S_SCAN: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(SCAN_LAST)) begin
                    n_state = r_after;
                end
            end
            obm_pkg::S_ADD_EVAL: begin
                n_oside = r_ctx.side;
                n_state = obm_pkg::S_IDLE;
                n_valid = 1'b1;
                n_sts   = obm_pkg::STS_DONE;
                if (r_first && r_tif == obm_pkg::TIF_FOK &&
                    i_scan.sum < {{(obm_pkg::SUM_W-32){1'b0}}, r_oqty}) begin
                    n_sts = obm_pkg::STS_KILLED;
                end else if (r_rem == '0) begin
                    n_sts = obm_pkg::STS_DONE;
                end else if (i_scan.m_found) begin
                    n_state   = obm_pkg::S_SCAN;
                    n_cnt     = '0;
                    n_first   = 1'b0;
                    n_last    = 1'b0;
                    n_sts     = obm_pkg::STS_TRADE;
                    n_rest_id = i_scan.m_id;
                    n_px      = i_scan.m_price;
                    n_cmd.idx = i_scan.m_idx;
                    if (i_scan.m_avail > r_rem) begin
                        n_tq         = r_rem;
                        n_kind       = obm_pkg::FK_AGGR;
                        n_cmd.op     = obm_pkg::CO_FILL;
                        n_cmd.filled = r_rem;
                        n_rem        = '0;
                    end else begin
                        n_tq     = i_scan.m_avail;
                        n_kind   = (i_scan.m_avail == r_rem) ? obm_pkg::FK_BOTH
                                                             : obm_pkg::FK_REST;
                        n_cmd.op = obm_pkg::CO_CLEAR;
                        n_rem    = r_rem - i_scan.m_avail;
                    end
                end else if (r_tif == obm_pkg::TIF_GTC && !r_ctx.market) begin
                    if (i_scan.e_found) begin
                        n_cmd.op      = obm_pkg::CO_WRITE;
                        n_cmd.idx     = i_scan.e_idx;
                        n_cmd.id      = r_ctx.id;
                        n_cmd.price   = r_ctx.price;
                        n_cmd.side    = r_ctx.side;
                        n_cmd.total   = r_oqty;
                        n_cmd.filled  = r_oqty - r_rem;
                        n_cmd.arrival = r_arrival;
                        n_arrival     = r_arrival + 1'b1;
                        n_sts         = obm_pkg::STS_RESTED;
                        n_rf          = r_oqty - r_rem;
                    end else begin
                        n_sts = obm_pkg::STS_FULL;
                    end
                end
                if (n_last && r_amend) begin
                    n_sts = obm_pkg::STS_AMENDED;
                end
            end
            obm_pkg::S_TGT_EVAL: begin
                n_state   = obm_pkg::S_IDLE;
                n_valid   = 1'b1;
                n_sts     = obm_pkg::STS_CANNOT;
                n_oside   = i_scan.f_side;
                n_cmd.idx = i_scan.f_idx;
                if (!i_scan.f_found) begin
                    n_oside = 1'b0;
                end else begin
                    case (r_req)
                        obm_pkg::REQ_CANCEL: begin
                            n_cmd.op = obm_pkg::CO_CLEAR;
                            n_sts    = obm_pkg::STS_CANCELLED;
                        end
                        obm_pkg::REQ_AMD_Q: begin
                            if (r_qty == i_scan.f_total || r_qty < i_scan.f_filled) begin
                                n_sts = obm_pkg::STS_CANNOT;
                            end else if (r_qty == i_scan.f_filled) begin
                                n_cmd.op = obm_pkg::CO_CLEAR;
                                n_sts    = obm_pkg::STS_REMOVED;
                            end else if (r_qty < i_scan.f_total) begin
                                n_cmd.op    = obm_pkg::CO_TOTAL;
                                n_cmd.total = r_qty;
                                n_sts       = obm_pkg::STS_IN_PLACE;
                            end else begin
                                n_cmd.op      = obm_pkg::CO_TOTAL_ARR;
                                n_cmd.total   = r_qty;
                                n_cmd.arrival = r_arrival;
                                n_arrival     = r_arrival + 1'b1;
                                n_sts         = obm_pkg::STS_AMENDED;
                            end
                        end
                        obm_pkg::REQ_AMD_P: begin
                            if (r_ctx.price != i_scan.f_price) begin
                                n_cmd.op = obm_pkg::CO_CLEAR;
                                n_rem    = i_scan.f_total - i_scan.f_filled;
                                n_oqty   = i_scan.f_total - i_scan.f_filled;
                                n_valid  = 1'b0;
                            end
                        end
                        default: begin
                            if ((r_ctx.price == i_scan.f_price && r_qty == i_scan.f_total) ||
                                r_qty < i_scan.f_filled) begin
                                n_sts = obm_pkg::STS_CANNOT;
                            end else if (r_qty == i_scan.f_filled) begin
                                n_cmd.op = obm_pkg::CO_CLEAR;
                                n_sts    = obm_pkg::STS_REMOVED;
                            end else if (r_ctx.price == i_scan.f_price &&
                                         r_qty < i_scan.f_total) begin
                                n_cmd.op    = obm_pkg::CO_TOTAL;
                                n_cmd.total = r_qty;
                                n_sts       = obm_pkg::STS_IN_PLACE;
                            end else begin
                                n_cmd.op = obm_pkg::CO_CLEAR;
                                n_rem    = r_qty - i_scan.f_filled;
                                n_oqty   = r_qty - i_scan.f_filled;
                                n_valid  = 1'b0;
                            end
                        end
                    endcase
                    // re-add as a GTC limit order on the stored side
                    if (!n_valid) begin
                        n_ctx.side   = i_scan.f_side;
                        n_ctx.market = 1'b0;
                        n_tif        = obm_pkg::TIF_GTC;
                        n_amend      = 1'b1;
                        n_first      = 1'b1;
                        n_cnt        = '0;
                        n_state      = obm_pkg::S_SCAN;
                        n_after      = obm_pkg::S_ADD_EVAL;
                    end
                end
            end
            default: begin
                n_state = obm_pkg::S_IDLE;
            end
        endcase
    end

    assign busy             = (r_state != obm_pkg::S_IDLE);
    assign o_cmd            = r_cmd;
    assign o_ctx            = r_ctx;
    assign o_valid          = r_valid;
    assign o_aggressor_id   = r_ctx.id;
    assign o_resting_id     = r_rest_id;
    assign o_trade_price    = r_px;
    assign o_trade_quantity = r_tq;
    assign o_aggressor_side = r_oside;
    assign o_fill_kind      = r_kind;
    assign o_status         = r_sts;
    assign o_rested_filled  = r_rf;
    assign o_last           = r_last;

endmodule

// ===== design/obm_checker.sv =====
// Port-level checks for the order book matcher, bound to the top level.
`include "order_book_matcher_macros.svh"
module obm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        busy,
    input logic        o_valid,
    input logic        o_last,
    input logic [3:0]  o_status,
    input logic [31:0] o_trade_quantity
);

    logic w_trade_ok;

    assign w_trade_ok = (o_status == obm_pkg::STS_TRADE) && (o_trade_quantity != 32'd0);

    `OBM_ASSERT_NOW(a_last_idle, i_clk, i_rst_n, o_valid && o_last, !busy)
    `OBM_ASSERT_NOW(a_trade_busy, i_clk, i_rst_n, o_valid && !o_last, busy)
    `OBM_ASSERT_NOW(a_mid_is_trade, i_clk, i_rst_n, o_valid && !o_last, w_trade_ok)
    `OBM_ASSERT_NEXT(a_status_nofill, i_clk, i_rst_n, 1'b1, !(o_valid && o_last) || o_trade_quantity == 32'd0)

endmodule

bind order_book_matcher obm_checker u_obm_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .busy            (busy),
    .o_valid         (o_valid),
    .o_last          (o_last),
    .o_status        (o_status),
    .o_trade_quantity(o_trade_quantity)
);
